// File: hw/rtl/bgrpp_pkg.sv
// Shared types and constants for the BGR binarize page packer.
// No dependencies; imported by bgr_binarize_page_packer.
package bgrpp_pkg;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_DISPLAY_WIDTH  = 2'd0,
      CSR_DISPLAY_PAGES  = 2'd1,
      CSR_GRAY_THRESHOLD = 2'd2
   } csr_index_type;

   // Luma weights, scaled by 256
   localparam int unsigned COEF_RED   = 77;
   localparam int unsigned COEF_GREEN = 150;
   localparam int unsigned COEF_BLUE  = 29;
   localparam int unsigned GRAY_SHIFT = 8;

   localparam int unsigned PIXEL_W      = 8;
   localparam int unsigned WEIGHTED_W   = 16;
   localparam int unsigned BYTE_INDEX_W = 10;
   localparam int unsigned STORE_BITS   = 7;
   localparam int unsigned PAGES_W      = 4;
   localparam int unsigned PAGE_ROWS    = 8;

   // Reset values of the configuration registers
   localparam logic [7:0]         WIDTH_RESET     = 8'd128;
   localparam logic [PAGES_W-1:0] PAGES_RESET     = 4'd8;
   localparam logic [7:0]         THRESHOLD_RESET = 8'd128;

endpackage

// File: hw/rtl/bgr_binarize_page_packer.sv
// BGR pixel binarizer and page packer, top level.
// Depends on bgrpp_pkg for register indexes, luma weights and field widths.
//
// One BGR pixel enters per transaction in raster order and the block sustains one
// transaction per clock. A pixel is held in stage 1 and its result in the result register;
// only the eighth row of each page gives a result. The per-column page bits live in a
// MAX_WIDTH-entry memory that is read as a pixel is accepted and written as it leaves
// stage 1; a write to the column that is read in the same cycle is bypassed, so even
// a one-column display runs at full rate. The input only stalls while a result is
// held back by rsp_stall. Configuration is written through the csr port, which is always
// ready, and should change only while no pixel is in flight.
module bgr_binarize_page_packer
   import bgrpp_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 128,
   parameter int unsigned MAX_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   // Pixel input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_green,
   input  logic [7:0] req_red,
   input  logic       req_frame_start,
   // Packed byte output channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_page_byte,
   output logic [9:0] rsp_byte_index,
   output logic       rsp_last_byte,
   // Configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int unsigned CW     = $clog2(MAX_WIDTH);
   localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW     = $clog2(MAX_HEIGHT);
   localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned MAXP   = (MAX_HEIGHT / PAGE_ROWS == 0) ? 1 : MAX_HEIGHT / PAGE_ROWS;
   localparam int unsigned IDX_CW = HW + WW + BYTE_INDEX_W;

   // Configuration registers
   logic [7:0]         display_width_ff;
   logic [PAGES_W-1:0] display_pages_ff;
   logic [7:0]         gray_threshold_ff;

   // Raster counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Stage 1: accepted pixel and its store entry
   logic                  s1_valid_ff;
   logic [7:0]            s1_blue_ff, s1_green_ff, s1_red_ff;
   logic [CW-1:0]         s1_col_ff;
   logic [RW-1:0]         s1_row_ff;
   logic                  s1_last_ff;
   logic [STORE_BITS-1:0] rd_ff;
   logic                  fwd_hit_ff;
   logic [STORE_BITS-1:0] fwd_data_ff;

   // Result register
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_page_byte_ff;
   logic [BYTE_INDEX_W-1:0] rsp_byte_index_ff;
   logic                    rsp_last_byte_ff;

   // Page bit store, undefined until written
   logic [STORE_BITS-1:0] store_mem [MAX_WIDTH];

   logic [WW-1:0]         eff_width;
   logic [HW-1:0]         eff_rows;
   logic                  req_accept;
   logic [CW-1:0]         acc_col;
   logic [RW-1:0]         acc_row;
   logic                  acc_last;
   logic                  s1_emit;
   logic                  s1_adv;
   logic                  mem_we;
   logic                  fwd_hit;
   logic                  pixel_bit;
   logic [STORE_BITS-1:0] rd_cur;
   logic [STORE_BITS-1:0] wdata;
   logic [BYTE_INDEX_W-1:0] byte_index;

   // Clamp the configured geometry to the supported range
   always_comb begin
      logic [4:0] pages_c;
      if (display_width_ff == 8'd0) begin
         eff_width = WW'(1);
      end else if ({1'b0, display_width_ff} > 9'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(display_width_ff);
      end
      if (display_pages_ff == '0) begin
         pages_c = 5'd1;
      end else if ({1'b0, display_pages_ff} > 5'(MAXP)) begin
         pages_c = 5'(MAXP);
      end else begin
         pages_c = {1'b0, display_pages_ff};
      end
      eff_rows = HW'({pages_c, 3'b000});
   end

   // Handshakes
   assign s1_emit    = (s1_row_ff[2:0] == 3'd7);
   assign s1_adv     = s1_valid_ff && (!s1_emit || !rsp_valid_ff || !rsp_stall);
   assign mem_we     = s1_adv && !s1_emit;
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Place the incoming pixel and advance the raster counters
   always_comb begin
      logic [WW-1:0] c_a, c_n;
      logic [HW-1:0] r_a, r_n;
      c_a = req_frame_start ? '0 : WW'(col_ff);
      r_a = req_frame_start ? '0 : HW'(row_ff);
      if (c_a >= eff_width) begin
         c_a = '0;
         r_a = r_a + 1'b1;
      end
      if (r_a >= eff_rows) begin
         r_a = '0;
      end
      acc_col  = CW'(c_a);
      acc_row  = RW'(r_a);
      acc_last = (r_a == eff_rows - 1'b1) && (c_a == eff_width - 1'b1);
      c_n = c_a + 1'b1;
      r_n = r_a;
      if (c_n >= eff_width) begin
         c_n = '0;
         r_n = r_a + 1'b1;
         if (r_n >= eff_rows) begin
            r_n = '0;
         end
      end
      col_in = req_accept ? CW'(c_n) : col_ff;
      row_in = req_accept ? RW'(r_n) : row_ff;
   end

   // Bypass the store write when the accepted pixel reads the same column
   assign fwd_hit = mem_we && (s1_col_ff == acc_col);

   // Binarize and merge into the column's page bits
   always_comb begin
      logic [WEIGHTED_W-1:0] weighted;
      logic [7:0]            gray;
      logic [STORE_BITS-1:0] mask;
      weighted = WEIGHTED_W'(COEF_RED) * WEIGHTED_W'(s1_red_ff)
               + WEIGHTED_W'(COEF_GREEN) * WEIGHTED_W'(s1_green_ff)
               + WEIGHTED_W'(COEF_BLUE) * WEIGHTED_W'(s1_blue_ff);
      gray      = 8'(weighted >> GRAY_SHIFT);
      pixel_bit = (gray >= gray_threshold_ff);
      rd_cur    = fwd_hit_ff ? fwd_data_ff : rd_ff;
      mask      = STORE_BITS'(1) << s1_row_ff[2:0];
      if (s1_row_ff[2:0] == 3'd0) begin
         wdata = STORE_BITS'(pixel_bit);
      end else if (pixel_bit) begin
         wdata = rd_cur | mask;
      end else begin
         wdata = rd_cur & ~mask;
      end
   end

   // Buffer index: page times width plus column
   always_comb begin
      logic [IDX_CW-1:0] idx_full;
      idx_full   = IDX_CW'(HW'(s1_row_ff) >> 3) * IDX_CW'(eff_width) + IDX_CW'(s1_col_ff);
      byte_index = BYTE_INDEX_W'(idx_full);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         display_width_ff  <= WIDTH_RESET;
         display_pages_ff  <= PAGES_RESET;
         gray_threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DISPLAY_WIDTH:  display_width_ff  <= csr_data;
            CSR_DISPLAY_PAGES:  display_pages_ff  <= csr_data[PAGES_W-1:0];
            CSR_GRAY_THRESHOLD: gray_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Control state: counters and valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv && s1_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the accepted transaction and read its store entry
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_blue_ff  <= req_blue;
         s1_green_ff <= req_green;
         s1_red_ff   <= req_red;
         s1_col_ff   <= acc_col;
         s1_row_ff   <= acc_row;
         s1_last_ff  <= acc_last;
         rd_ff       <= store_mem[acc_col];
         fwd_hit_ff  <= fwd_hit;
         fwd_data_ff <= wdata;
      end
   end

   // Write back the merged page bits
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[s1_col_ff] <= wdata;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit) begin
         rsp_page_byte_ff  <= {pixel_bit, rd_cur};
         rsp_byte_index_ff <= byte_index;
         rsp_last_byte_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_byte  = rsp_page_byte_ff;
   assign rsp_byte_index = rsp_byte_index_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;

   // A frame start always lands on the top-left pixel
   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_frame_start) |=> (s1_col_ff == '0 && s1_row_ff == '0))
      else $error("frame start did not map to column 0, row 0");

   // An emitting pixel that leaves stage 1 produces a result next cycle
   a_emit_result: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit) |=> rsp_valid_ff)
      else $error("last-row pixel advanced without a result");

   // The input only stalls when stage 1 is occupied
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with an empty stage");

   // The bypass is taken only behind a store write
   a_bypass_write: assert property (@(posedge clock) disable iff (reset)
      ($past(req_accept) && fwd_hit_ff) |-> $past(mem_we))
      else $error("bypass taken without a store write");

endmodule
